@@ sv/frame_delta_rle_compressor_macros.svh @@
// assertion macros shared by the compressor rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef FRAME_DELTA_RLE_COMPRESSOR_MACROS_SVH
`define FRAME_DELTA_RLE_COMPRESSOR_MACROS_SVH

// checked only while out of reset
`define FDRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define FDRC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ sv/fdrc_pkg.sv @@
// types and constants for the frame delta run-length compressor
// no dependencies
`default_nettype none

package fdrc_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned LimitW     = 11;
  localparam logic [LimitW-1:0] LimitReset = 11'd1024;
  localparam logic [ByteW-1:0]  RunMax     = 8'd255;

  // output queue sizing: a frame end can push two words per cycle
  localparam int unsigned FifoDepth = 8;
  localparam int unsigned FifoIdxW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);
  localparam int unsigned FifoSlack = 4;

  typedef struct packed {
    logic [ByteW-1:0] iq_byte;
    logic             frame_end;
  } in_word_t;

  typedef struct packed {
    logic [ByteW-1:0] run_count;
    logic [ByteW-1:0] delta_value;
    logic             last_of_frame;
    logic             overflow;
  } out_word_t;

  // byte that came back from the frame store, valid in the cycle after accept
  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] iq_byte;
    logic             frame_end;
    logic             in_range;
    logic             ref_hit;
  } lookup_t;

  // which result words the run coder pushes this cycle
  typedef struct packed {
    logic a_valid;
    logic b_valid;
  } push_t;

endpackage

`default_nettype wire

@@ sv/fdrc_stream_if.sv @@
// valid/ready stream channel carrying one word of a given payload type
// used by the compressor top level for its input and output
`default_nettype none

interface fdrc_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ sv/fdrc_frame_store.sv @@
// previous frame store: byte position, fill mark and a registered-read memory
// depends on fdrc_pkg
`default_nettype none

module fdrc_frame_store #(
  parameter int unsigned MAX_FRAME_BYTES = 512
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire fdrc_pkg::in_word_t word_i,
  output fdrc_pkg::lookup_t      look_o,
  output logic [fdrc_pkg::ByteW-1:0] prev_byte_o
);
  import fdrc_pkg::*;

  localparam int unsigned PosW  = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned AddrW = $clog2(MAX_FRAME_BYTES);
  localparam logic [PosW-1:0] MaxPos = PosW'(MAX_FRAME_BYTES);

  logic [ByteW-1:0] mem [MAX_FRAME_BYTES];
  logic [ByteW-1:0] rdata_q;

  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] fill_q, fill_d;
  logic            look_valid_q;
  logic [ByteW-1:0] look_byte_q;
  logic            look_end_q, look_range_q, look_hit_q;

  logic            in_range;
  logic            ref_hit;
  logic [AddrW-1:0] addr;

  assign in_range = (pos_q < MaxPos);
  // entries at or above the fill mark were never written since reset
  assign ref_hit  = (pos_q < fill_q);
  assign addr     = pos_q[AddrW-1:0];

  // position and fill mark update
  always_comb begin
    pos_d  = pos_q;
    fill_d = fill_q;
    if (accept_i) begin
      if (in_range && (pos_q == fill_q)) begin
        fill_d = fill_q + PosW'(1);
      end
      if (word_i.frame_end) begin
        pos_d = '0;
      end else if (in_range) begin
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      fill_q       <= '0;
      look_valid_q <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      fill_q       <= fill_d;
      look_valid_q <= accept_i;
    end
  end

  // read old byte and write the new one at the same position
  always_ff @(posedge clk_i) begin
    if (accept_i && in_range) begin
      rdata_q   <= mem[addr];
      mem[addr] <= word_i.iq_byte;
    end
  end

  // side information that travels with the read
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      look_byte_q  <= word_i.iq_byte;
      look_end_q   <= word_i.frame_end;
      look_range_q <= in_range;
      look_hit_q   <= ref_hit;
    end
  end

  assign look_o.valid     = look_valid_q;
  assign look_o.iq_byte   = look_byte_q;
  assign look_o.frame_end = look_end_q;
  assign look_o.in_range  = look_range_q;
  assign look_o.ref_hit   = look_hit_q;
  assign prev_byte_o      = rdata_q;

endmodule

`default_nettype wire

@@ sv/fdrc_run_coder.sv @@
// run-length coder over xor deltas, output limit and overflow marker
// depends on fdrc_pkg and the assertion macro header
`default_nettype none
`include "frame_delta_rle_compressor_macros.svh"

module fdrc_run_coder #(
  parameter int unsigned MAX_FRAME_BYTES = 512
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire fdrc_pkg::lookup_t          look_i,
  input  wire logic [fdrc_pkg::ByteW-1:0] prev_byte_i,
  input  wire logic [fdrc_pkg::LimitW-1:0] limit_i,
  output fdrc_pkg::push_t                 push_o,
  output fdrc_pkg::out_word_t             word_a_o,
  output fdrc_pkg::out_word_t             word_b_o
);
  import fdrc_pkg::*;

  localparam int unsigned PairW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned CmpW  = (PairW + 2 > LimitW + 1) ? PairW + 2 : LimitW + 1;

  logic             have_ref_q, have_ref_d;
  logic [ByteW-1:0] value_q, value_d;
  logic [ByteW-1:0] count_q, count_d;
  logic [PairW-1:0] pairs_q, pairs_d;
  logic             limit_hit_q, limit_hit_d;

  logic [ByteW-1:0] prev_eff, delta;
  logic [ByteW-1:0] v1, c1;
  logic [PairW-1:0] p1;
  logic             l1, l2;
  logic             mid_pair;

  // a pair fits while 2 * (pairs + 1) stays within the limit
  function automatic logic pair_fits(input logic [PairW-1:0] p,
                                     input logic [LimitW-1:0] lim);
    logic [CmpW-1:0] need;
    need = CmpW'({p, 1'b0}) + CmpW'(2);
    return need <= CmpW'(lim);
  endfunction

  assign prev_eff = look_i.ref_hit ? prev_byte_i : '0;
  assign delta    = look_i.iq_byte ^ prev_eff;

  // run extension, pair emission and frame end handling
  always_comb begin
    have_ref_d  = have_ref_q;
    value_d     = value_q;
    count_d     = count_q;
    pairs_d     = pairs_q;
    limit_hit_d = limit_hit_q;
    v1 = value_q;
    c1 = count_q;
    p1 = pairs_q;
    l1 = limit_hit_q;
    l2 = limit_hit_q;
    push_o   = '0;
    word_a_o = '{run_count: count_q, delta_value: value_q,
                 last_of_frame: 1'b0, overflow: 1'b0};
    word_b_o = '{run_count: c1, delta_value: v1,
                 last_of_frame: 1'b1, overflow: 1'b0};
    if (look_i.valid) begin
      if (look_i.in_range && have_ref_q) begin
        if ((count_q != '0) && (delta == value_q) && (count_q != RunMax)) begin
          c1 = count_q + 8'd1;
        end else begin
          if ((count_q != '0) && !limit_hit_q) begin
            if (pair_fits(pairs_q, limit_i)) begin
              push_o.a_valid = 1'b1;
              p1 = pairs_q + PairW'(1);
            end else begin
              l1 = 1'b1;
            end
          end
          v1 = delta;
          c1 = 8'd1;
        end
      end
      if (look_i.frame_end) begin
        if (have_ref_q) begin
          l2 = l1;
          if ((c1 != '0) && !l1) begin
            if (pair_fits(p1, limit_i)) begin
              push_o.b_valid = 1'b1;
              word_b_o = '{run_count: c1, delta_value: v1,
                           last_of_frame: 1'b1, overflow: 1'b0};
            end else begin
              l2 = 1'b1;
            end
          end
          // overflow marker replaces the final pair
          if (l2) begin
            push_o.b_valid = 1'b1;
            word_b_o = '{run_count: '0, delta_value: '0,
                         last_of_frame: 1'b1, overflow: 1'b1};
          end
        end
        have_ref_d  = 1'b1;
        value_d     = '0;
        count_d     = '0;
        pairs_d     = '0;
        limit_hit_d = 1'b0;
      end else begin
        value_d     = v1;
        count_d     = c1;
        pairs_d     = p1;
        limit_hit_d = l1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_ref_q  <= 1'b0;
      value_q     <= '0;
      count_q     <= '0;
      pairs_q     <= '0;
      limit_hit_q <= 1'b0;
    end else begin
      have_ref_q  <= have_ref_d;
      value_q     <= value_d;
      count_q     <= count_d;
      pairs_q     <= pairs_d;
      limit_hit_q <= limit_hit_d;
    end
  end

  assign mid_pair = push_o.a_valid && !look_i.frame_end;

  // a second word only comes with the last byte of a frame
  `FDRC_ASSERT(a_second_word_at_end, push_o.b_valid |-> look_i.frame_end, "second word off end")
  // a mid-frame pair is counted against the limit
  `FDRC_ASSERT(a_pair_counted, mid_pair |=> pairs_q == $past(pairs_q) + PairW'(1), "pair uncounted")

endmodule

`default_nettype wire

@@ sv/fdrc_out_fifo.sv @@
// output queue: up to two words pushed per cycle, one word popped
// depends on fdrc_pkg, fdrc_stream_if and the assertion macro header
`default_nettype none
`include "frame_delta_rle_compressor_macros.svh"

module fdrc_out_fifo (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire fdrc_pkg::push_t     push_i,
  input  wire fdrc_pkg::out_word_t word_a_i,
  input  wire fdrc_pkg::out_word_t word_b_i,
  output logic                     room_o,
  fdrc_stream_if.source            out_o
);
  import fdrc_pkg::*;

  out_word_t mem [FifoDepth];
  logic [FifoIdxW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [FifoCntW-1:0] cnt_q, cnt_d;
  logic [1:0]          npush;
  logic                pop;
  logic [FifoCntW:0]   fill_sum;

  assign npush = {1'b0, push_i.a_valid} + {1'b0, push_i.b_valid};
  assign pop   = out_o.valid && out_o.ready;

  assign out_o.valid = (cnt_q != '0);
  assign out_o.data  = mem[rd_q];
  // room for the item in flight plus this one, two words each
  assign room_o      = (cnt_q <= FifoCntW'(FifoDepth - FifoSlack));

  assign fill_sum = {1'b0, cnt_q} + (FifoCntW + 1)'(npush);

  // pointer and count update
  always_comb begin
    wr_d  = wr_q + FifoIdxW'(npush);
    rd_d  = pop ? rd_q + FifoIdxW'(1) : rd_q;
    cnt_d = cnt_q + FifoCntW'(npush) - FifoCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // word a goes first, word b after it or alone
  always_ff @(posedge clk_i) begin
    if (push_i.a_valid) begin
      mem[wr_q] <= word_a_i;
      if (push_i.b_valid) begin
        mem[wr_q + FifoIdxW'(1)] <= word_b_i;
      end
    end else if (push_i.b_valid) begin
      mem[wr_q] <= word_b_i;
    end
  end

  `FDRC_ASSERT_ALWAYS(a_no_overrun, fill_sum <= (FifoCntW + 1)'(FifoDepth), "queue overrun")
  `FDRC_ASSERT(a_pop_drains, pop && npush == 2'd0 |=> cnt_q == $past(cnt_q) - 1'b1, "pop lost")

endmodule

`default_nettype wire

@@ sv/frame_delta_rle_compressor.sv @@
// top level of the frame delta run-length compressor
// depends on fdrc_pkg, fdrc_stream_if, fdrc_frame_store, fdrc_run_coder, fdrc_out_fifo
//
//   channel   dir   word                                          handshake
//   in_i      in    iq_byte, frame_end                            valid/ready
//   out_o     out   run_count, delta_value, last_of_frame, overflow valid/ready
//   cfg       in    output_byte_limit (11 bit)                    cfg_we_i, no ready
//
// one input word per cycle while in_i.ready is high; a result word passes the
// frame store lookup register and the output queue before it can be taken.
// the frame store memory is read and written on the accepting edge, the run
// coder works on the returned byte in the next cycle and pushes 0..2 words.
// in_i.ready drops while the output queue holds more than four words.
// reset needs no clearing pass: a fill mark makes never-written store entries
// read zero.
`default_nettype none

module frame_delta_rle_compressor #(
  parameter int unsigned MAX_FRAME_BYTES = 512
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  fdrc_stream_if.sink                      in_i,
  fdrc_stream_if.source                    out_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [fdrc_pkg::LimitW-1:0] cfg_wdata_i
);
  import fdrc_pkg::*;

  logic [LimitW-1:0] limit_q;
  logic              accept;
  logic              room;
  lookup_t           look;
  logic [ByteW-1:0]  prev_byte;
  push_t             push;
  out_word_t         word_a, word_b;

  assign in_i.ready = room;
  assign accept     = in_i.valid && in_i.ready;

  // output byte limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  fdrc_frame_store #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .word_i     (in_i.data),
    .look_o     (look),
    .prev_byte_o(prev_byte)
  );

  fdrc_run_coder #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_coder (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .look_i     (look),
    .prev_byte_i(prev_byte),
    .limit_i    (limit_q),
    .push_o     (push),
    .word_a_o   (word_a),
    .word_b_o   (word_b)
  );

  fdrc_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .word_a_i(word_a),
    .word_b_i(word_b),
    .room_o  (room),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

@@ tb/sv/fdrc_pair_checker.sv @@
`timescale 1ns / 1ps
// scoreboard for the frame delta run-length compressor: predicts the
// (count, delta) words of every frame and compares them with the output channel
// depends on fdrc_pkg
module fdrc_pair_checker #(
  parameter int unsigned MAX_FRAME_BYTES = 512
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  fdrc_pkg::in_word_t          in_data_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  fdrc_pkg::out_word_t         out_data_i,
  input  logic                        cfg_we_i,
  input  logic [fdrc_pkg::LimitW-1:0] cfg_wdata_i,
  output int                          fail_count_o,
  output int                          pending_o
);
  import fdrc_pkg::*;

  localparam int MaxReports = 10;

  // shadow of the block state
  logic [ByteW-1:0] prev_frame [MAX_FRAME_BYTES];
  logic             have_ref;
  int unsigned      byte_pos;
  logic [ByteW-1:0] run_val;
  int unsigned      run_len;
  int unsigned      pairs_out;
  logic             limit_hit;
  int unsigned      byte_limit;

  out_word_t pair_queue [$];
  int        mismatches = 0;

  // emit the open run if it still fits under the byte limit
  task automatic flush_run(input logic last);
    out_word_t w;
    if (run_len != 0 && !limit_hit) begin
      if (2 * (pairs_out + 1) > byte_limit) begin
        limit_hit = 1'b1;
      end else begin
        pairs_out++;
        w.run_count     = 8'(run_len);
        w.delta_value   = run_val;
        w.last_of_frame = last;
        w.overflow      = 1'b0;
        pair_queue.push_back(w);
      end
    end
  endtask

  // delta against the stored frame, extend or close the run, finish at frame end
  task automatic encode_byte(input in_word_t w);
    logic [ByteW-1:0] delta;
    out_word_t        marker;
    if (byte_pos < MAX_FRAME_BYTES) begin
      delta = w.iq_byte ^ prev_frame[byte_pos];
      prev_frame[byte_pos] = w.iq_byte;
      byte_pos++;
      if (have_ref) begin
        if (run_len != 0 && delta == run_val && run_len < 32'(RunMax)) begin
          run_len++;
        end else begin
          flush_run(1'b0);
          run_val = delta;
          run_len = 1;
        end
      end
    end
    if (w.frame_end) begin
      if (have_ref) begin
        flush_run(1'b1);
        // overflow marker replaces the final pair
        if (limit_hit) begin
          marker = '0;
          marker.last_of_frame = 1'b1;
          marker.overflow      = 1'b1;
          pair_queue.push_back(marker);
        end
      end
      have_ref  = 1'b1;
      byte_pos  = 0;
      run_len   = 0;
      run_val   = '0;
      pairs_out = 0;
      limit_hit = 1'b0;
    end
  endtask

  // compare one output word with the oldest prediction
  task automatic check_word(input out_word_t got);
    out_word_t want;
    if (pair_queue.size() == 0) begin
      mismatches++;
      if (mismatches <= MaxReports) begin
        $display("%0t: unexpected word count %0d delta %02h last %0b ovf %0b", $realtime,
                 got.run_count, got.delta_value, got.last_of_frame, got.overflow);
      end
    end else begin
      want = pair_queue.pop_front();
      if (got.run_count !== want.run_count || got.delta_value !== want.delta_value ||
          got.last_of_frame !== want.last_of_frame || got.overflow !== want.overflow) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("%0t: word mismatch exp count %0d delta %02h last %0b ovf %0b", $realtime,
                   want.run_count, want.delta_value, want.last_of_frame, want.overflow);
          $display("%0t:                 got count %0d delta %02h last %0b ovf %0b", $realtime,
                   got.run_count, got.delta_value, got.last_of_frame, got.overflow);
        end
      end
    end
  endtask

  // watch config, input and output at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_FRAME_BYTES; i++) prev_frame[i] = '0;
      have_ref   = 1'b0;
      byte_pos   = 0;
      run_val    = '0;
      run_len    = 0;
      pairs_out  = 0;
      limit_hit  = 1'b0;
      byte_limit = 32'(LimitReset);
      pair_queue.delete();
    end else begin
      if (cfg_we_i) byte_limit = 32'(cfg_wdata_i);
      if (in_valid_i && in_ready_i) encode_byte(in_data_i);
      if (out_valid_i && out_ready_i) check_word(out_data_i);
    end
    pending_o    = pair_queue.size();
    fail_count_o = mismatches;
  end

endmodule

@@ tb/sv/frame_delta_rle_compressor_tb.sv @@
`timescale 1ns / 1ps
// top of the compressor testbench: clock, reset, frame stimulus and verdict
// depends on fdrc_pkg, fdrc_stream_if, frame_delta_rle_compressor, fdrc_pair_checker
module frame_delta_rle_compressor_tb;
  import fdrc_pkg::*;

  localparam int unsigned MaxFrame   = 512;
  localparam int unsigned TailCycles = 16;
  localparam int          PhaseItems = 110;

  // how the bytes of a frame relate to the stored frame
  typedef enum int unsigned {
    ModeRandom,
    ModeRepeat,
    ModeRuns,
    ModeDrift
  } fill_mode_e;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we;
  logic [LimitW-1:0] cfg_wdata;
  int                fail_count;
  int                pending;
  int                send_idle_pct;
  int                recv_stall_pct;
  int                items_sent;
  int                phase_start;
  int unsigned       frame_pos;
  logic [ByteW-1:0]  store_copy [MaxFrame];

  fdrc_stream_if #(.payload_t(in_word_t))  in_ch ();
  fdrc_stream_if #(.payload_t(out_word_t)) out_ch ();

  frame_delta_rle_compressor #(
    .MAX_FRAME_BYTES(MaxFrame)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  fdrc_pair_checker #(
    .MAX_FRAME_BYTES(MaxFrame)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_i  (in_ch.ready),
    .in_data_i   (in_ch.data),
    .out_valid_i (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .out_data_i  (out_ch.data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #(4_000_000);
    $display("status: fail");
    $finish;
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  // offer one word, hold it until accepted, keep a copy of the frame store
  task automatic send_word(input logic [ByteW-1:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid = 1'b1;
    in_ch.data  = {b, last};
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
    if (frame_pos < MaxFrame) store_copy[frame_pos] = b;
    frame_pos = last ? 0 : frame_pos + 1;
  endtask

  // build a frame of len bytes whose deltas follow the chosen mode
  task automatic send_frame(input int unsigned len, input fill_mode_e mode);
    logic [ByteW-1:0] old;
    logic [ByteW-1:0] b;
    logic [ByteW-1:0] run_delta;
    int unsigned      run_left;
    run_left  = 0;
    run_delta = '0;
    for (int unsigned i = 0; i < len; i++) begin
      old = (i < MaxFrame) ? store_copy[i] : 8'($urandom);
      case (mode)
        ModeRandom: begin
          b = 8'($urandom);
        end
        ModeRepeat: begin
          b = old;
        end
        ModeRuns: begin
          if (run_left == 0) begin
            run_delta = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom);
            run_left  = $urandom_range(1, 8);
          end
          run_left--;
          b = old ^ run_delta;
        end
        default: begin
          if ($urandom_range(1) != 0) run_delta = 8'($urandom);
          b = old ^ run_delta;
        end
      endcase
      send_word(b, i == len - 1);
    end
  endtask

  // wait until every predicted word is out and the pipeline has settled
  task automatic drain_pairs();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [LimitW-1:0] v);
    drain_pairs();
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk_i);
    cfg_we    = 1'b0;
  endtask

  // mostly tight limits so overflow shows up, sometimes the extremes
  function automatic logic [LimitW-1:0] pick_limit();
    case ($urandom_range(9))
      0:       return LimitW'($urandom_range(1));
      1:       return '1;
      2, 3:    return LimitReset;
      4:       return LimitW'($urandom);
      default: return LimitW'($urandom_range(2, 30));
    endcase
  endfunction

  // short frames mostly, a few past the frame size
  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(1, 16);
    if (r < 97) return $urandom_range(17, 80);
    return $urandom_range(500, 530);
  endfunction

  // stimulus
  initial begin
    in_ch.valid    = 1'b0;
    in_ch.data     = '0;
    out_ch.ready   = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    rst_ni         = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    items_sent     = 0;
    phase_start    = 0;
    frame_pos      = 0;
    for (int i = 0; i < MaxFrame; i++) store_copy[i] = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reference frame, yields nothing
    send_word(8'h00, 1'b0); send_word(8'hff, 1'b0);
    send_word(8'h80, 1'b0); send_word(8'h01, 1'b1);
    // same frame: one run of zero deltas
    send_word(8'h00, 1'b0); send_word(8'hff, 1'b0);
    send_word(8'h80, 1'b0); send_word(8'h01, 1'b1);
    // inverted frame: one run of all-ones deltas
    send_word(8'hff, 1'b0); send_word(8'h00, 1'b0);
    send_word(8'h7f, 1'b0); send_word(8'hfe, 1'b1);
    // single byte frame
    send_word(8'h5a, 1'b1);
    // room for one pair only, then the overflow marker
    write_limit(LimitW'(2));
    send_word(8'h00, 1'b0); send_word(8'h00, 1'b0); send_word(8'h00, 1'b1);
    // no pair fits at all
    write_limit('0);
    send_word(8'h12, 1'b0); send_word(8'h34, 1'b1);
    // largest limit
    write_limit('1);
    send_word(8'hff, 1'b0); send_word(8'h00, 1'b1);

    // random phases with different idle and stall mixes
    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 7;  recv_stall_pct = 7;  end
      endcase
      // long frames: runs split at the maximum count, bytes past the frame dropped
      if (p == 0) begin
        write_limit(LimitReset);
        send_frame(520, ModeRepeat);
      end
      if (p == 2) begin
        write_limit(LimitW'(1000));
        send_frame(512, ModeRandom);
      end
      phase_start = items_sent;
      while (items_sent - phase_start < PhaseItems) begin
        if ($urandom_range(5) == 0) write_limit(pick_limit());
        send_frame(pick_len(), fill_mode_e'($urandom_range(3)));
      end
    end

    recv_stall_pct = 0;
    drain_pairs();
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/fdrc_pkg.sv
sv/fdrc_stream_if.sv
sv/fdrc_frame_store.sv
sv/fdrc_run_coder.sv
sv/fdrc_out_fifo.sv
sv/frame_delta_rle_compressor.sv
tb/sv/fdrc_pair_checker.sv
tb/sv/frame_delta_rle_compressor_tb.sv
